FILE: sv/fswps_pkg.sv
// Package with shared types, constants and state codes of the packet scheduler.
`default_nettype none
package fswps_pkg;

    localparam int NUM_CLASSES_DEF    = 4;
    localparam int CLASS_DEPTH_DEF    = 16;
    localparam int TIME_FRAC_BITS_DEF = 8;
    localparam int RING_DEPTH         = 64;
    localparam int TIME_W             = 40;
    localparam int CFG_W              = 32;
    localparam int CFG_IDX_W          = 3;
    localparam int ENTRY_W            = 35;

    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_FIFOLIM = 3'd1;
    localparam logic [2:0] CFG_CLIMITS = 3'd2;
    localparam logic [2:0] CFG_WEIGHTS = 3'd3;
    localparam logic [2:0] CFG_INUSE   = 3'd4;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_DEQUEUED = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_SPQ  = 2'd1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] packet_tag;
        logic [2:0]  packet_class;
        logic [15:0] packet_size;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_tag;
        logic [2:0]  out_class;
        logic [15:0] out_size;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RD,
        S_RDWAIT,
        S_DIV,
        S_CMP,
        S_POP,
        S_POPWAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;

endpackage
`default_nettype wire

FILE: sv/fswps_ram.sv
// Generic single-port-write, registered-read memory.
`default_nettype none
module fswps_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/fswps_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module fswps_div #(
    parameter int NW = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NW-1:0]       num,
    input  wire logic [7:0]          den,
    output fswps_pkg::div_ctl_t      ctl,
    output logic      [NW-1:0]       quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [7:0]    rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [7:0]    den_reg, den_next;
    logic [8:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[NW-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 8'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign quo       = quo_reg;
endmodule
`default_nettype wire

FILE: sv/fifo_spq_wfq_packet_scheduler.sv
// Top level of the FIFO / strict-priority / weighted fair queuing packet scheduler.
// One item is handled at a time: in_stall is high from the accepting edge until the
// item's result beat is loaded into the output register, which waits while an earlier
// beat is still stalled. An enqueue or an empty FIFO dequeue goes from the decide state
// straight to the output state, a FIFO dequeue passes through the pop and pop-wait
// states, and a strict-priority dequeue scans the classes one at a time up to the one
// served (through all of them when all are empty) before the pop. A weighted fair
// queuing dequeue reads each class head through the one packet memory read port and
// runs the one shared bit-serial divider of 16+TIME_FRAC_BITS steps on each non-empty
// class and skips each empty class. Packets live in one memory of
// max(64, NUM_CLASSES*CLASS_DEPTH) entries that needs no clearing after reset.
`default_nettype none
module fifo_spq_wfq_packet_scheduler #(
    parameter int NUM_CLASSES    = fswps_pkg::NUM_CLASSES_DEF,
    parameter int CLASS_DEPTH    = fswps_pkg::CLASS_DEPTH_DEF,
    parameter int TIME_FRAC_BITS = fswps_pkg::TIME_FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire fswps_pkg::in_item_t             in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output fswps_pkg::out_item_t                 out_data,
    input  wire logic                            cfg_we,
    input  wire logic [fswps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fswps_pkg::CFG_W-1:0]     cfg_value
);
    localparam int STORE  = (NUM_CLASSES * CLASS_DEPTH > fswps_pkg::RING_DEPTH) ?
                            NUM_CLASSES * CLASS_DEPTH : fswps_pkg::RING_DEPTH;
    localparam int AW     = $clog2(STORE);
    localparam int CIW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PW     = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CNTW   = $clog2(CLASS_DEPTH + 1);
    localparam int NW     = 16 + TIME_FRAC_BITS;
    localparam int TW     = fswps_pkg::TIME_W;
    localparam int RW     = $clog2(fswps_pkg::RING_DEPTH);

    fswps_pkg::state_t state_reg, state_next;

    logic [1:0]  mode_reg;
    logic [6:0]  fifo_limit_reg;
    logic [19:0] climits_reg;
    logic [31:0] weights_reg;
    logic [2:0]  inuse_reg;

    logic [PW-1:0]   head_reg [NUM_CLASSES];
    logic [PW-1:0]   tail_reg [NUM_CLASSES];
    logic [CNTW-1:0] cnt_reg  [NUM_CLASSES];
    logic [TW-1:0]   lastfin_reg [NUM_CLASSES];
    logic [RW-1:0]   ring_head_reg, ring_tail_reg;
    logic [6:0]      ring_count_reg;
    logic [TW-1:0]   vclock_reg;

    fswps_pkg::in_item_t  item_reg;
    fswps_pkg::out_item_t res_reg, res_next;
    logic                 out_valid_reg;

    logic [CIW-1:0] scan_reg, scan_next;
    logic           found_reg, found_next;
    logic [CIW-1:0] best_reg, best_next;
    logic [TW-1:0]  best_tag_reg, best_tag_next;
    logic [TW-1:0]  start_reg;

    // Memory ports.
    logic                                we;
    logic [AW-1:0]                       waddr, raddr;
    logic [fswps_pkg::ENTRY_W-1:0]       wdata, rdata;

    // Divider.
    logic            div_start;
    logic [NW-1:0]   div_quo;
    fswps_pkg::div_ctl_t div_ctl;
    logic [7:0]      cur_weight;

    logic            in_acc;
    logic [CIW-1:0]  cls_idx;
    logic            cls_bad;
    logic [4:0]      cls_lim;
    logic            cls_full;
    logic [6:0]      ring_lim;
    logic            last_scan;
    logic [TW:0]     fin_sum;
    logic [TW-1:0]   fin;
    logic            do_enq, do_pop_cls, do_pop_ring, do_wfq_upd;

    assign in_acc = in_valid && !in_stall;

    fswps_ram #(.WIDTH(fswps_pkg::ENTRY_W), .DEPTH(STORE)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    fswps_div #(.NW(NW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({rdata[34:19], {TIME_FRAC_BITS{1'b0}}}),
        .den   (cur_weight),
        .ctl   (div_ctl),
        .quo   (div_quo)
    );

    function automatic logic [4:0] lim_of(input logic [19:0] lims, input int c);
        logic [4:0] l;
        l = 5'(CLASS_DEPTH);
        if (c < 4)
        begin
            l = lims[5*c +: 5];
            if (32'(l) > CLASS_DEPTH)
            begin
                l = 5'(CLASS_DEPTH);
            end
        end
        return l;
    endfunction

    always_comb
    begin
        cls_idx  = CIW'(item_reg.packet_class - 3'd1);
        cls_bad  = (item_reg.packet_class == 3'd0) ||
                   (item_reg.packet_class > inuse_reg) ||
                   (32'(item_reg.packet_class) > NUM_CLASSES);
        cls_lim  = lim_of(climits_reg, 32'(cls_idx));
        cls_full = 32'(cnt_reg[cls_idx]) >= 32'(cls_lim);
        ring_lim = (fifo_limit_reg > 7'(fswps_pkg::RING_DEPTH)) ?
                   7'(fswps_pkg::RING_DEPTH) : fifo_limit_reg;
        last_scan = (32'(scan_reg) == NUM_CLASSES - 1);
        cur_weight = 8'd1;
        if (32'(scan_reg) < 4)
        begin
            cur_weight = weights_reg[8*scan_reg +: 8];
            if (cur_weight == 8'd0)
            begin
                cur_weight = 8'd1;
            end
        end
        fin_sum = {1'b0, start_reg} + (TW+1)'(div_quo);
        fin     = fin_sum[TW] ? {TW{1'b1}} : fin_sum[TW-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fswps_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = fswps_pkg::S_DECIDE;
                end
            end
            fswps_pkg::S_DECIDE:
            begin
                if (item_reg.opcode == fswps_pkg::OP_ENQ)
                begin
                    state_next = fswps_pkg::S_OUT;
                end
                else if (mode_reg == fswps_pkg::MODE_FIFO)
                begin
                    state_next = (ring_count_reg == 7'd0) ? fswps_pkg::S_OUT
                                                           : fswps_pkg::S_POP;
                end
                else
                begin
                    state_next = fswps_pkg::S_RD;
                end
            end
            fswps_pkg::S_RD:
            begin
                if (cnt_reg[scan_reg] != '0)
                begin
                    state_next = (mode_reg == fswps_pkg::MODE_SPQ) ? fswps_pkg::S_POP
                                                                  : fswps_pkg::S_RDWAIT;
                end
                else if (last_scan)
                begin
                    state_next = found_reg ? fswps_pkg::S_POP : fswps_pkg::S_OUT;
                end
            end
            fswps_pkg::S_RDWAIT:
            begin
                state_next = fswps_pkg::S_DIV;
            end
            fswps_pkg::S_DIV:
            begin
                if (!div_ctl.busy && !div_ctl.start)
                begin
                    state_next = fswps_pkg::S_CMP;
                end
            end
            fswps_pkg::S_CMP:
            begin
                state_next = last_scan ? fswps_pkg::S_POP : fswps_pkg::S_RD;
            end
            fswps_pkg::S_POP:
            begin
                state_next = fswps_pkg::S_POPWAIT;
            end
            fswps_pkg::S_POPWAIT:
            begin
                state_next = fswps_pkg::S_OUT;
            end
            fswps_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = fswps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fswps_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        we            = 1'b0;
        waddr         = '0;
        wdata         = {item_reg.packet_size, item_reg.packet_class, item_reg.packet_tag};
        raddr         = '0;
        div_start     = 1'b0;
        scan_next     = scan_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_tag_next = best_tag_reg;
        res_next      = res_reg;
        do_enq        = 1'b0;
        do_pop_cls    = 1'b0;
        do_pop_ring   = 1'b0;
        do_wfq_upd    = 1'b0;
        unique case (state_reg)
            fswps_pkg::S_IDLE:
            begin
                scan_next  = '0;
                found_next = 1'b0;
                best_next  = '0;
            end
            fswps_pkg::S_DECIDE:
            begin
                res_next = '0;
                if (item_reg.opcode == fswps_pkg::OP_ENQ)
                begin
                    if (cls_bad)
                    begin
                        res_next.status = fswps_pkg::ST_INVALID;
                    end
                    else if (mode_reg == fswps_pkg::MODE_FIFO)
                    begin
                        if (ring_count_reg >= ring_lim)
                        begin
                            res_next.status = fswps_pkg::ST_DROPPED;
                        end
                        else
                        begin
                            we     = 1'b1;
                            waddr  = AW'(ring_tail_reg);
                            do_enq = 1'b1;
                        end
                    end
                    else if (cls_full)
                    begin
                        res_next.status = fswps_pkg::ST_DROPPED;
                    end
                    else
                    begin
                        we     = 1'b1;
                        waddr  = AW'(32'(cls_idx) * CLASS_DEPTH + 32'(tail_reg[cls_idx]));
                        do_enq = 1'b1;
                    end
                end
                else
                begin
                    res_next.status = fswps_pkg::ST_EMPTY;
                end
            end
            fswps_pkg::S_RD:
            begin
                raddr = AW'(32'(scan_reg) * CLASS_DEPTH + 32'(head_reg[scan_reg]));
                if (cnt_reg[scan_reg] != '0)
                begin
                    if (mode_reg == fswps_pkg::MODE_SPQ)
                    begin
                        best_next  = scan_reg;
                        found_next = 1'b1;
                    end
                end
                else if (!last_scan)
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            fswps_pkg::S_RDWAIT:
            begin
                div_start = 1'b1;
            end
            fswps_pkg::S_CMP:
            begin
                if (!found_reg || fin < best_tag_reg)
                begin
                    found_next    = 1'b1;
                    best_next     = scan_reg;
                    best_tag_next = fin;
                end
                if (!last_scan)
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            fswps_pkg::S_POP:
            begin
                if (mode_reg == fswps_pkg::MODE_FIFO)
                begin
                    raddr       = AW'(ring_head_reg);
                    do_pop_ring = 1'b1;
                end
                else
                begin
                    raddr      = AW'(32'(best_reg) * CLASS_DEPTH + 32'(head_reg[best_reg]));
                    do_pop_cls = 1'b1;
                    do_wfq_upd = (mode_reg != fswps_pkg::MODE_SPQ);
                end
            end
            fswps_pkg::S_POPWAIT:
            begin
                res_next.status    = fswps_pkg::ST_DEQUEUED;
                res_next.out_tag   = rdata[15:0];
                res_next.out_class = rdata[18:16];
                res_next.out_size  = rdata[34:19];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fswps_pkg::S_IDLE;
            mode_reg       <= fswps_pkg::MODE_FIFO;
            fifo_limit_reg <= 7'd64;
            climits_reg    <= 20'd541200;
            weights_reg    <= 32'd16843009;
            inuse_reg      <= 3'd4;
            ring_head_reg  <= '0;
            ring_tail_reg  <= '0;
            ring_count_reg <= '0;
            vclock_reg     <= '0;
            out_valid_reg  <= 1'b0;
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i]    <= '0;
                tail_reg[i]    <= '0;
                cnt_reg[i]     <= '0;
                lastfin_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            found_reg <= found_next;
            best_reg  <= best_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fswps_pkg::CFG_MODE:    mode_reg       <= cfg_value[1:0];
                    fswps_pkg::CFG_FIFOLIM: fifo_limit_reg <= cfg_value[6:0];
                    fswps_pkg::CFG_CLIMITS: climits_reg    <= cfg_value[19:0];
                    fswps_pkg::CFG_WEIGHTS: weights_reg    <= cfg_value[31:0];
                    fswps_pkg::CFG_INUSE:   inuse_reg      <= cfg_value[2:0];
                    default:
                    begin
                    end
                endcase
            end
            if (do_enq)
            begin
                if (mode_reg == fswps_pkg::MODE_FIFO)
                begin
                    ring_tail_reg  <= ring_tail_reg + 1'b1;
                    ring_count_reg <= ring_count_reg + 1'b1;
                end
                else
                begin
                    tail_reg[cls_idx] <= (32'(tail_reg[cls_idx]) + 1 >= CLASS_DEPTH) ?
                                         '0 : tail_reg[cls_idx] + 1'b1;
                    cnt_reg[cls_idx]  <= cnt_reg[cls_idx] + 1'b1;
                end
            end
            if (do_pop_ring)
            begin
                ring_head_reg  <= ring_head_reg + 1'b1;
                ring_count_reg <= ring_count_reg - 1'b1;
            end
            if (do_pop_cls)
            begin
                head_reg[best_reg] <= (32'(head_reg[best_reg]) + 1 >= CLASS_DEPTH) ?
                                      '0 : head_reg[best_reg] + 1'b1;
                cnt_reg[best_reg]  <= cnt_reg[best_reg] - 1'b1;
            end
            if (do_wfq_upd)
            begin
                vclock_reg            <= best_tag_reg;
                lastfin_reg[best_reg] <= best_tag_reg;
            end
            if (state_reg == fswps_pkg::S_OUT && state_next == fswps_pkg::S_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= in_data;
        end
        best_tag_reg <= best_tag_next;
        if (state_reg == fswps_pkg::S_RDWAIT)
        begin
            start_reg <= (vclock_reg > lastfin_reg[scan_reg]) ? vclock_reg
                                                              : lastfin_reg[scan_reg];
        end
        if (state_reg == fswps_pkg::S_OUT && state_next == fswps_pkg::S_IDLE)
        begin
            out_data <= res_reg;
        end
        res_reg <= res_next;
    end

    assign in_stall  = (state_reg != fswps_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire
